// ===== src/dts_pkg.sv =====
// ----------------------------------------------------------------------------
// Delayed task scheduler package
// Operation codes, default sizes and the control bundle for the ring head.
// ----------------------------------------------------------------------------
package dts_pkg;

    localparam int NUM_TASKS_DEF  = 64;
    localparam int DELAY_BITS_DEF = 16;

    localparam int OP_W    = 3;
    localparam int TASK_W  = 6;
    localparam int DLY_IN_W = 16;

    localparam logic [OP_W-1:0] OP_REQ     = 3'd0;
    localparam logic [OP_W-1:0] OP_REQ_DLY = 3'd1;
    localparam logic [OP_W-1:0] OP_RR_REQ  = 3'd2;
    localparam logic [OP_W-1:0] OP_TICK    = 3'd3;
    localparam logic [OP_W-1:0] OP_SELECT  = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            task_hit;
        logic            blocked;
    } head_ctl_t;

endpackage

// ===== src/delayed_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// Delayed task scheduler
// Fixed-priority task scheduler with round robin and per-task delays, built
// as a ring of task cells that rotates once past a shared head per request.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Ports                      | Payload
//  s_       | in        | s_tvalid s_tready s_tdata  | op, task_req, delay
//  m_       | out       | m_tvalid m_tready m_tdata  | grant_valid, grant_task, mode
//
// Each request is taken in the idle state; the ring then shifts one cell per cycle,
// except while a stalled result holds the last shift, and every task passes the
// head once, in index order. The result is registered at the last shift of the
// scan.
// A request is taken only while the block is idle; the result then sits in
// an output register, so the next request may start before it is taken.
// A stalled result holds the last shift of the following scan.
// Reset clears every cell, the mode and the last grant.
// ----------------------------------------------------------------------------
module delayed_task_scheduler #(
    parameter int NUM_TASKS  = dts_pkg::NUM_TASKS_DEF,
    parameter int DELAY_BITS = dts_pkg::DELAY_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // op[2:0], task_req[8:3], delay[24:9], zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // grant_valid[0], grant_task[6:1], round_robin_mode[7]
);

    localparam int CW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int MW = (CW > dts_pkg::TASK_W) ? CW : dts_pkg::TASK_W;
    localparam logic [CW-1:0] LAST_IDX = CW'(NUM_TASKS - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                          state_reg, state_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic [dts_pkg::OP_W-1:0]      op_reg, op_next;
    logic [dts_pkg::TASK_W-1:0]    task_reg, task_next;
    logic [dts_pkg::DLY_IN_W-1:0]  dly_reg, dly_next;
    logic                          found_reg, found_next;
    logic [CW-1:0]                 gidx_reg, gidx_next;
    logic                          rr_reg, rr_next;
    logic                          lg_valid_reg, lg_valid_next;
    logic [CW-1:0]                 lg_reg, lg_next;
    logic                          m_valid_reg, m_valid_next;
    logic [7:0]                    m_data_reg, m_data_next;

    logic                          pend_q [NUM_TASKS];
    logic                          mark_q [NUM_TASKS];
    logic [DELAY_BITS-1:0]         wait_q [NUM_TASKS];

    logic                          head_pend, head_mark, grant;
    logic [DELAY_BITS-1:0]         head_wait;
    logic [DELAY_BITS-1:0]         dly_load;
    logic [DELAY_BITS+dts_pkg::DLY_IN_W-1:0] dly_ext;
    dts_pkg::head_ctl_t            ctl;
    logic                          last, shift_en;
    logic                          got_grant, rr_final;
    logic [CW-1:0]                 out_idx;

    assign dly_ext  = {{DELAY_BITS{1'b0}}, dly_reg};
    assign dly_load = dly_ext[DELAY_BITS-1:0];

    assign last     = (cnt_reg == LAST_IDX);
    assign shift_en = (state_reg == ST_SCAN) && !(last && m_valid_reg && !m_tready);

    assign ctl.op       = op_reg;
    assign ctl.task_hit = (MW'(cnt_reg) == MW'(task_reg));
    assign ctl.blocked  = found_reg || (rr_reg && lg_valid_reg && (cnt_reg <= lg_reg));

    dts_head #(.DELAY_BITS(DELAY_BITS)) u_head (
        .ctl      (ctl),
        .dly_load (dly_load),
        .pend_i   (pend_q[0]),
        .mark_i   (mark_q[0]),
        .wait_i   (wait_q[0]),
        .pend_o   (head_pend),
        .mark_o   (head_mark),
        .wait_o   (head_wait),
        .grant    (grant)
    );

    for (genvar i = 0; i < NUM_TASKS; i++) begin : g_ring
        if (i == NUM_TASKS - 1) begin : g_tail
            dts_cell #(.DELAY_BITS(DELAY_BITS)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .pend_in  (head_pend),
                .mark_in  (head_mark),
                .wait_in  (head_wait),
                .pend_out (pend_q[i]),
                .mark_out (mark_q[i]),
                .wait_out (wait_q[i])
            );
        end else begin : g_body
            dts_cell #(.DELAY_BITS(DELAY_BITS)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .pend_in  (pend_q[i+1]),
                .mark_in  (mark_q[i+1]),
                .wait_in  (wait_q[i+1]),
                .pend_out (pend_q[i]),
                .mark_out (mark_q[i]),
                .wait_out (wait_q[i])
            );
        end
    end

    assign got_grant = found_reg || grant;
    assign out_idx   = grant ? cnt_reg : gidx_reg;
    assign rr_final  = rr_reg || (grant && head_mark);

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        op_next       = op_reg;
        task_next     = task_reg;
        dly_next      = dly_reg;
        found_next    = found_reg;
        gidx_next     = gidx_reg;
        rr_next       = rr_reg;
        lg_valid_next = lg_valid_reg;
        lg_next       = lg_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tdata[2:0];
                    task_next  = s_tdata[8:3];
                    dly_next   = s_tdata[24:9];
                    cnt_next   = '0;
                    found_next = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (shift_en) begin
                    cnt_next = cnt_reg + 1'b1;
                    if (grant) begin
                        found_next    = 1'b1;
                        gidx_next     = cnt_reg;
                        lg_next       = cnt_reg;
                        lg_valid_next = 1'b1;
                        rr_next       = rr_final;
                    end
                    if (last) begin
                        state_next   = ST_IDLE;
                        m_valid_next = 1'b1;
                        m_data_next  = {rr_reg, 7'd0};
                        case (op_reg)
                            dts_pkg::OP_SELECT: begin
                                if (got_grant) begin
                                    m_data_next = {rr_final, dts_pkg::TASK_W'(out_idx), 1'b1};
                                end else begin
                                    lg_valid_next = 1'b0;
                                    rr_next       = 1'b0;
                                    m_data_next   = 8'd0;
                                end
                            end
                            dts_pkg::OP_CLEAR: begin
                                lg_valid_next = 1'b0;
                                rr_next       = 1'b0;
                                m_data_next   = 8'd0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            found_reg    <= 1'b0;
            rr_reg       <= 1'b0;
            lg_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            found_reg    <= found_next;
            rr_reg       <= rr_next;
            lg_valid_reg <= lg_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        op_reg     <= op_next;
        task_reg   <= task_next;
        dly_reg    <= dly_next;
        gidx_reg   <= gidx_next;
        lg_reg     <= lg_next;
        m_data_reg <= m_data_next;
    end

    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== src/dts_cell.sv =====
// ----------------------------------------------------------------------------
// Task cell
// Holds one task's pending bit, round-robin mark and delay, and takes its
// neighbor's entry whenever the ring shifts.
// ----------------------------------------------------------------------------
module dts_cell #(
    parameter int DELAY_BITS = dts_pkg::DELAY_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  shift_en,
    input  logic                  pend_in,
    input  logic                  mark_in,
    input  logic [DELAY_BITS-1:0] wait_in,
    output logic                  pend_out,
    output logic                  mark_out,
    output logic [DELAY_BITS-1:0] wait_out
);

    logic                  pend_reg, pend_next;
    logic                  mark_reg, mark_next;
    logic [DELAY_BITS-1:0] wait_reg, wait_next;

    always_comb begin
        pend_next = shift_en ? pend_in : pend_reg;
        mark_next = shift_en ? mark_in : mark_reg;
        wait_next = shift_en ? wait_in : wait_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
            mark_reg <= 1'b0;
            wait_reg <= '0;
        end else begin
            pend_reg <= pend_next;
            mark_reg <= mark_next;
            wait_reg <= wait_next;
        end
    end

    assign pend_out = pend_reg;
    assign mark_out = mark_reg;
    assign wait_out = wait_reg;

endmodule

// ===== src/dts_head.sv =====
// ----------------------------------------------------------------------------
// Ring head
// Applies the current request to the entry leaving the head of the ring.
// ----------------------------------------------------------------------------
module dts_head #(
    parameter int DELAY_BITS = dts_pkg::DELAY_BITS_DEF
) (
    input  dts_pkg::head_ctl_t    ctl,
    input  logic [DELAY_BITS-1:0] dly_load,
    input  logic                  pend_i,
    input  logic                  mark_i,
    input  logic [DELAY_BITS-1:0] wait_i,
    output logic                  pend_o,
    output logic                  mark_o,
    output logic [DELAY_BITS-1:0] wait_o,
    output logic                  grant
);

    always_comb begin
        pend_o = pend_i;
        mark_o = mark_i;
        wait_o = wait_i;
        grant  = 1'b0;
        case (ctl.op)
            dts_pkg::OP_REQ: begin
                if (ctl.task_hit) pend_o = 1'b1;
            end
            dts_pkg::OP_REQ_DLY: begin
                if (ctl.task_hit) begin
                    pend_o = 1'b1;
                    wait_o = dly_load;
                end
            end
            dts_pkg::OP_RR_REQ: begin
                if (ctl.task_hit) begin
                    pend_o = 1'b1;
                    wait_o = dly_load;
                    mark_o = 1'b1;
                end
            end
            dts_pkg::OP_TICK: begin
                if (wait_i != '0) wait_o = wait_i - 1'b1;
            end
            dts_pkg::OP_SELECT: begin
                if (pend_i && (wait_i == '0) && !ctl.blocked) begin
                    pend_o = 1'b0;
                    grant  = 1'b1;
                end
            end
            dts_pkg::OP_CLEAR: begin
                pend_o = 1'b0;
                wait_o = '0;
            end
            default: begin
            end
        endcase
    end

endmodule
